FILE: rtl/tick_task_scheduler_table_defines.svh
// assertion macros shared by the scheduler rtl
`ifndef TICK_TASK_SCHEDULER_TABLE_DEFINES_SVH
`define TICK_TASK_SCHEDULER_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define TTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tts assertion failed");

// next-cycle implication, checked out of reset
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tts assertion failed");

`else

`define TTS_ASSERT_NOW(label, ante, cons)
`define TTS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/tts_pkg.sv
package tts_pkg;

  // opcodes of an input transaction
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_DISP = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY_DEL = 2'd2;
  localparam logic [1:0] ST_NONE_DUE  = 2'd3;

  // sticky error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_MANY  = 2'd1;
  localparam logic [1:0] ERR_NO_DELETE = 2'd2;

  // most slots served by one dispatch
  localparam int MAX_OUT = 8;
  localparam int CNT_W   = $clog2(MAX_OUT);

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic        tick;
    logic        start;
    logic        advance;
    logic        kill;
    logic        claim;
    logic        take;
    logic        del;
    logic [7:0]  handle;
    logic [15:0] delay;
    logic [15:0] period;
  } cell_cmd_t;

  // what one cell shows
  typedef struct packed {
    logic       tok;
    logic       valid;
    logic       due;
    logic [7:0] handle;
  } cell_stat_t;

  // row status seen by the sequencer
  typedef struct packed {
    logic       free_hit;
    logic       due_hit;
    logic       del_valid;
    logic [7:0] handle;
  } scan_stat_t;

endpackage

FILE: rtl/tick_task_scheduler_table.sv
// Cooperative time-triggered task scheduler table: a row of NUM_SLOTS slot cells, each holding
// one task's handle, delay, period and pending-run count, run by a small sequencer. Tick and
// delete are answered at the edge that accepts them, so the next item can be taken as soon as
// the output is not stalled. Add and dispatch walk a token down the row one cell per cycle
// after acceptance. Add keeps in_stall high until the token reaches the lowest free slot (the
// last slot when the table is full), its result appearing as the scan ends. Dispatch keeps it
// high until the token passes the last slot or eight tasks are served, then closes in S_FLUSH.
// Each result is one transaction; out_last marks the last result of an item. A new item is taken
// only once the previous one has finished its scan, and a stalled output holds the scan in place.
`include "tick_task_scheduler_table_defines.svh"

module tick_task_scheduler_table #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_handle,
  input  logic [15:0] in_first_delay,
  input  logic [15:0] in_repeat_period,
  input  logic [2:0]  in_target_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_slot,
  output logic [7:0]  out_run_handle,
  output logic [1:0]  out_error_latch,
  output logic        out_last
);

  tts_pkg::cell_cmd_t  cmd;
  tts_pkg::scan_stat_t scan_stat;
  tts_pkg::cell_stat_t cell_stat [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] tok_vec;
  logic [NUM_SLOTS-1:0] tok_in_vec;
  logic [NUM_SLOTS-1:0] sel_vec;
  logic [NUM_SLOTS-1:0] del_hit_vec;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in_vec[i] = cmd.start;
    end else begin : g_body
      assign tok_in_vec[i] = tok_vec[i-1];
    end

    // out-of-range targets select no cell
    assign sel_vec[i]     = (int'(in_target_slot) == i);
    assign del_hit_vec[i] = cmd.del && sel_vec[i];
    assign tok_vec[i]     = cell_stat[i].tok;

    tts_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .del_hit (del_hit_vec[i]),
      .tok_in  (tok_in_vec[i]),
      .stat    (cell_stat[i])
    );
  end

  // token is one-hot at most, so an or across the row picks the token cell
  always_comb begin
    scan_stat = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tok_vec[i]) begin
        scan_stat.free_hit = scan_stat.free_hit | !cell_stat[i].valid;
        scan_stat.due_hit  = scan_stat.due_hit | cell_stat[i].due;
        scan_stat.handle   = scan_stat.handle | cell_stat[i].handle;
      end
      if (sel_vec[i]) begin
        scan_stat.del_valid = scan_stat.del_valid | cell_stat[i].valid;
      end
    end
  end

  tts_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_handle        (in_handle),
    .in_first_delay   (in_first_delay),
    .in_repeat_period (in_repeat_period),
    .in_target_slot   (in_target_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_run_handle   (out_run_handle),
    .out_error_latch  (out_error_latch),
    .out_last         (out_last),
    .stat             (scan_stat),
    .cmd              (cmd)
  );

  `TTS_ASSERT_NOW(a_token_onehot, 1'b1, $onehot0(tok_vec))
  `TTS_ASSERT_NEXT(a_token_cleared_on_kill, cmd.kill, (tok_vec == '0))

endmodule

FILE: rtl/tts_cell.sv
module tts_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tts_pkg::cell_cmd_t  cmd,
  input  logic                del_hit,
  input  logic                tok_in,
  output tts_pkg::cell_stat_t stat
);

  logic        valid_r, valid_nxt;
  logic        tok_r, tok_nxt;
  logic [7:0]  handle_r, handle_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [15:0] period_r, period_nxt;
  logic [7:0]  runs_r, runs_nxt;

  always_comb begin
    valid_nxt  = valid_r;
    handle_nxt = handle_r;
    delay_nxt  = delay_r;
    period_nxt = period_r;
    runs_nxt   = runs_r;

    if (cmd.tick && valid_r) begin
      if (delay_r == 16'd0) begin
        if (runs_r != 8'hFF) begin
          runs_nxt = runs_r + 8'd1;
        end
        if (period_r != 16'd0) begin
          delay_nxt = period_r;
        end
      end else begin
        delay_nxt = delay_r - 16'd1;
      end
    end

    if (cmd.claim && tok_r) begin
      valid_nxt  = 1'b1;
      handle_nxt = cmd.handle;
      delay_nxt  = cmd.delay;
      period_nxt = cmd.period;
      runs_nxt   = 8'd0;
    end

    // one-shot tasks drop out after their first run
    if (cmd.take && tok_r) begin
      runs_nxt = runs_r - 8'd1;
      if (period_r == 16'd0) begin
        valid_nxt = 1'b0;
      end
    end

    if (del_hit) begin
      valid_nxt = 1'b0;
    end

    if (cmd.kill) begin
      tok_nxt = 1'b0;
    end else if (cmd.advance) begin
      tok_nxt = tok_in;
    end else begin
      tok_nxt = tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r <= handle_nxt;
    delay_r  <= delay_nxt;
    period_r <= period_nxt;
    runs_r   <= runs_nxt;
  end

  assign stat.tok    = tok_r;
  assign stat.valid  = valid_r;
  assign stat.due    = valid_r && (runs_r != 8'd0);
  assign stat.handle = handle_r;

endmodule

FILE: rtl/tts_ctrl.sv
`include "tick_task_scheduler_table_defines.svh"

module tts_ctrl #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [7:0]          in_handle,
  input  logic [15:0]         in_first_delay,
  input  logic [15:0]         in_repeat_period,
  input  logic [2:0]          in_target_slot,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [2:0]          out_slot,
  output logic [7:0]          out_run_handle,
  output logic [1:0]          out_error_latch,
  output logic                out_last,
  input  tts_pkg::scan_stat_t stat,
  output tts_pkg::cell_cmd_t  cmd
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int EXT_W = (IDX_W > 3) ? IDX_W : 3;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);
  localparam logic [tts_pkg::CNT_W-1:0] CNT_LAST = tts_pkg::CNT_W'(tts_pkg::MAX_OUT - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ADD   = 2'd1;
  localparam logic [1:0] S_DISP  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [tts_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                err_r, err_nxt;
  logic                      hold_v_r, hold_v_nxt;
  logic [2:0]                hold_slot_r, hold_slot_nxt;
  logic [7:0]                hold_handle_r, hold_handle_nxt;
  logic [7:0]                add_handle_r, add_handle_nxt;
  logic [15:0]               add_delay_r, add_delay_nxt;
  logic [15:0]               add_period_r, add_period_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic [2:0]                out_slot_r, out_slot_nxt;
  logic [7:0]                out_handle_r, out_handle_nxt;
  logic [1:0]                out_err_r, out_err_nxt;
  logic                      out_last_r, out_last_nxt;

  logic             accept;
  logic             out_free;
  logic             load;
  logic [EXT_W-1:0] idx_ext;
  logic [2:0]       idx_slot;

  assign idx_ext  = EXT_W'(idx_r);
  assign idx_slot = idx_ext[2:0];
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    err_nxt         = err_r;
    hold_v_nxt      = hold_v_r;
    hold_slot_nxt   = hold_slot_r;
    hold_handle_nxt = hold_handle_r;
    add_handle_nxt  = add_handle_r;
    add_delay_nxt   = add_delay_r;
    add_period_nxt  = add_period_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_handle_nxt  = out_handle_r;
    out_last_nxt    = out_last_r;
    load            = 1'b0;

    cmd        = '0;
    cmd.handle = add_handle_r;
    cmd.delay  = add_delay_r;
    cmd.period = add_period_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            tts_pkg::OP_TICK: begin
              cmd.tick       = 1'b1;
              load           = 1'b1;
              out_status_nxt = tts_pkg::ST_OK;
              out_slot_nxt   = 3'd0;
              out_handle_nxt = 8'd0;
              out_last_nxt   = 1'b1;
            end
            tts_pkg::OP_DEL: begin
              cmd.del        = 1'b1;
              load           = 1'b1;
              out_status_nxt = tts_pkg::ST_OK;
              out_slot_nxt   = in_target_slot;
              out_handle_nxt = 8'd0;
              out_last_nxt   = 1'b1;
              if (!stat.del_valid) begin
                err_nxt        = tts_pkg::ERR_NO_DELETE;
                out_status_nxt = tts_pkg::ST_EMPTY_DEL;
              end
            end
            tts_pkg::OP_ADD: begin
              add_handle_nxt = in_handle;
              add_delay_nxt  = in_first_delay;
              add_period_nxt = in_repeat_period;
              cmd.start      = 1'b1;
              cmd.advance    = 1'b1;
              idx_nxt        = '0;
              state_nxt      = S_ADD;
            end
            tts_pkg::OP_DISP: begin
              cmd.start   = 1'b1;
              cmd.advance = 1'b1;
              idx_nxt     = '0;
              cnt_nxt     = '0;
              hold_v_nxt  = 1'b0;
              state_nxt   = S_DISP;
            end
            default: begin
            end
          endcase
        end
      end

      S_ADD: begin
        if (out_free) begin
          if (stat.free_hit) begin
            cmd.claim      = 1'b1;
            cmd.kill       = 1'b1;
            load           = 1'b1;
            out_status_nxt = tts_pkg::ST_OK;
            out_slot_nxt   = idx_slot;
            out_handle_nxt = 8'd0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else if (idx_r == IDX_LAST) begin
            cmd.kill       = 1'b1;
            err_nxt        = tts_pkg::ERR_TOO_MANY;
            load           = 1'b1;
            out_status_nxt = tts_pkg::ST_FULL;
            out_slot_nxt   = 3'd0;
            out_handle_nxt = 8'd0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            idx_nxt     = idx_r + 1'b1;
          end
        end
      end

      S_DISP: begin
        if (stat.due_hit) begin
          // the held result goes out only once a later one proves it is not last
          if (!hold_v_r || out_free) begin
            cmd.take = 1'b1;
            if (hold_v_r) begin
              load           = 1'b1;
              out_status_nxt = tts_pkg::ST_OK;
              out_slot_nxt   = hold_slot_r;
              out_handle_nxt = hold_handle_r;
              out_last_nxt   = 1'b0;
            end
            hold_v_nxt      = 1'b1;
            hold_slot_nxt   = idx_slot;
            hold_handle_nxt = stat.handle;
            cnt_nxt         = cnt_r + 1'b1;
            if ((cnt_r == CNT_LAST) || (idx_r == IDX_LAST)) begin
              cmd.kill  = 1'b1;
              state_nxt = S_FLUSH;
            end else begin
              cmd.advance = 1'b1;
              idx_nxt     = idx_r + 1'b1;
            end
          end
        end else if (idx_r == IDX_LAST) begin
          cmd.kill  = 1'b1;
          state_nxt = S_FLUSH;
        end else begin
          cmd.advance = 1'b1;
          idx_nxt     = idx_r + 1'b1;
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          load         = 1'b1;
          out_last_nxt = 1'b1;
          if (hold_v_r) begin
            out_status_nxt = tts_pkg::ST_OK;
            out_slot_nxt   = hold_slot_r;
            out_handle_nxt = hold_handle_r;
          end else begin
            out_status_nxt = tts_pkg::ST_NONE_DUE;
            out_slot_nxt   = 3'd0;
            out_handle_nxt = 8'd0;
          end
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end
    out_err_nxt = load ? err_nxt : out_err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      err_r       <= tts_pkg::ERR_NONE;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    cnt_r         <= cnt_nxt;
    hold_slot_r   <= hold_slot_nxt;
    hold_handle_r <= hold_handle_nxt;
    add_handle_r  <= add_handle_nxt;
    add_delay_r   <= add_delay_nxt;
    add_period_r  <= add_period_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_handle_r  <= out_handle_nxt;
    out_err_r     <= out_err_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_run_handle  = out_handle_r;
  assign out_error_latch = out_err_r;
  assign out_last        = out_last_r;

  `TTS_ASSERT_NOW(a_hold_only_in_dispatch, hold_v_r, (state_r == S_DISP || state_r == S_FLUSH))
  `TTS_ASSERT_NOW(a_add_scan_out_empty, (state_r == S_ADD), !out_valid_r)
  `TTS_ASSERT_NEXT(a_claim_gives_last, cmd.claim, (out_valid_r && out_last_r))

endmodule
